FILE: src/weight_settle_event_logger_top_assert.svh
// Assertion helpers shared by the logger modules.
`ifndef WEIGHT_SETTLE_EVENT_LOGGER_TOP_ASSERT_SVH
`define WEIGHT_SETTLE_EVENT_LOGGER_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define WSEL_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("wsel assertion failed");
// Next-cycle implication.
`define WSEL_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("wsel assertion failed");
`else
`define WSEL_ASSERT_NOW(lbl, ck, rn, ante, cons)
`define WSEL_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

FILE: src/wsel_pkg.sv
package wsel_pkg;

  localparam int RAW_BITS             = 24;
  localparam int WEIGHT_FRAC_BITS_DEF = 4;
  localparam int SCALE_W              = 24;
  localparam int THR_W                = 16;
  localparam int TIME_W               = 32;
  localparam int WEIGHT_W             = 32;
  localparam int CFG_W                = (RAW_BITS > SCALE_W) ? RAW_BITS : SCALE_W;
  localparam int CFG_IDX_W            = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHG    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 3'd4;

  // Register reset values
  localparam logic [RAW_BITS-1:0] TARE_RST   = '0;
  localparam logic [SCALE_W-1:0]  SCALE_RST  = 24'd110080;
  localparam logic [THR_W-1:0]    PRES_RST   = 16'd160;
  localparam logic [THR_W-1:0]    CHG_RST    = 16'd240;
  localparam logic [THR_W-1:0]    SETTLE_RST = 16'd3000;

  // Logger modes
  localparam logic [1:0] MODE_IDLE       = 2'd0;
  localparam logic [1:0] MODE_WEIGHING   = 2'd1;
  localparam logic [1:0] MODE_LOGGED     = 2'd2;
  localparam logic [1:0] MODE_REWEIGHING = 2'd3;

  // Event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_LOGGED  = 2'd1;
  localparam logic [1:0] EV_UPDATED = 2'd2;
  localparam logic [1:0] EV_REMOVED = 2'd3;

  typedef struct packed {
    logic                       read_ok;
    logic signed [RAW_BITS-1:0] raw_reading;
    logic [TIME_W-1:0]          time_ms;
  } wsel_in_t;

  typedef struct packed {
    logic [1:0]                 mode;
    logic signed [WEIGHT_W-1:0] weight;
    logic [1:0]                 event_res;
    logic signed [WEIGHT_W-1:0] held_weight;
  } wsel_out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic sat;
    logic cmp;
    logic commit;
  } wsel_cmd_t;

  typedef struct packed {
    logic out_free;
  } wsel_sts_t;

endpackage

FILE: src/weight_settle_event_logger_top.sv
// Weight settle event logger. Each accepted beat carries one averaged load-cell
// reading and its millisecond timestamp. A beat with read_ok low is accepted and
// gives no result and no state change. A valid beat has the tare
// subtracted, is divided by the Q8 counts-per-gram scale (weight in units of
// 2^-WEIGHT_FRAC_BITS g, truncated toward zero, saturated to signed 32 bits; a
// zero scale gives the limit of the difference's sign) and then steps the
// idle / weighing / logged / reweighing logger, giving exactly one result beat
// with the new mode, the weight, an event code and the last logged weight.
// A valid reading passes through an accept state, the bit-serial restoring
// divider, then saturation, threshold compares and commit; the block takes no
// new reading until that reading has been committed.
// The result register lets the next reading enter while a result still waits
// for out_ready; commit stalls only if the previous result is still unread.
// Write configuration only while the block is idle.
module weight_settle_event_logger_top #(
  parameter int WEIGHT_FRAC_BITS = wsel_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [wsel_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wsel_pkg::CFG_W-1:0]     cfg_wdata,
  // reading channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  wsel_pkg::wsel_in_t             in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output wsel_pkg::wsel_out_t            out_data
);
  import wsel_pkg::*;

  // commands from the sequencer, status back from the datapath
  wsel_cmd_t cmd;
  wsel_sts_t sts;

  // Sequencer: accept, iterate the divider, saturate, compare, commit.
  wsel_ctrl #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_read_ok (in_data.read_ok),
    .in_ready   (in_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Datapath: config registers, divider, logger state and result register.
  wsel_dp #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: src/wsel_ctrl.sv
`include "weight_settle_event_logger_top_assert.svh"

module wsel_ctrl #(
  parameter int WEIGHT_FRAC_BITS = wsel_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_read_ok,
  output logic               in_ready,
  input  wsel_pkg::wsel_sts_t sts,
  output wsel_pkg::wsel_cmd_t cmd
);
  import wsel_pkg::*;

  localparam int DIV_W = RAW_BITS + 9 + WEIGHT_FRAC_BITS;
  localparam int CNT_W = $clog2(DIV_W);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SAT  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_read_ok) begin
          cmd.load  = 1'b1;
          cnt_nxt   = CNT_W'(DIV_W - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_SAT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `WSEL_ASSERT_NOW(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0({cmd.load, cmd.step, cmd.sat, cmd.cmp, cmd.commit}))
  `WSEL_ASSERT_NEXT(a_load_starts_div, clk, rst_n, cmd.load, (state_r == S_DIV) && (cnt_r == CNT_W'(DIV_W - 1)))
  `WSEL_ASSERT_NOW(a_commit_free, clk, rst_n, cmd.commit, sts.out_free)

endmodule

FILE: src/wsel_dp.sv
`include "weight_settle_event_logger_top_assert.svh"

module wsel_dp #(
  parameter int WEIGHT_FRAC_BITS = wsel_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [wsel_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wsel_pkg::CFG_W-1:0]     cfg_wdata,
  input  wsel_pkg::wsel_in_t             in_data,
  input  wsel_pkg::wsel_cmd_t            cmd,
  output wsel_pkg::wsel_sts_t            sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output wsel_pkg::wsel_out_t            out_data
);
  import wsel_pkg::*;

  localparam int SHIFT = 8 + WEIGHT_FRAC_BITS;
  localparam int MAG_W = RAW_BITS + 1;
  localparam int DIV_W = MAG_W + SHIFT;

  localparam logic [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

  // Configuration registers
  logic [RAW_BITS-1:0] tare_r;
  logic [SCALE_W-1:0]  scale_r;
  logic [THR_W-1:0]    pres_r, chg_r, settle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tare_r   <= TARE_RST;
      scale_r  <= SCALE_RST;
      pres_r   <= PRES_RST;
      chg_r    <= CHG_RST;
      settle_r <= SETTLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARE:   tare_r   <= cfg_wdata[RAW_BITS-1:0];
        REG_SCALE:  scale_r  <= cfg_wdata[SCALE_W-1:0];
        REG_PRES:   pres_r   <= cfg_wdata[THR_W-1:0];
        REG_CHG:    chg_r    <= cfg_wdata[THR_W-1:0];
        REG_SETTLE: settle_r <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Tare subtraction and magnitude
  logic [MAG_W-1:0] diff, mag;
  assign diff = {in_data.raw_reading[RAW_BITS-1], in_data.raw_reading}
              - {tare_r[RAW_BITS-1], tare_r};
  assign mag  = diff[MAG_W-1] ? (~diff + 1'b1) : diff;

  // Restoring divider, one quotient bit per step
  logic              neg_r, zero_r;
  logic [DIV_W-1:0]  dvd_r;
  logic [SCALE_W-1:0] rem_r;
  logic [TIME_W-1:0] now_r;
  logic [SCALE_W:0]  rem_sh, rem_sub;
  logic              ge;

  assign rem_sh  = {rem_r, dvd_r[DIV_W-1]};
  assign ge      = (rem_sh >= {1'b0, scale_r});
  assign rem_sub = rem_sh - {1'b0, scale_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r  <= diff[MAG_W-1];
      zero_r <= (diff == '0);
      dvd_r  <= {mag, {SHIFT{1'b0}}};
      rem_r  <= '0;
      now_r  <= in_data.time_ms;
    end else if (cmd.step) begin
      dvd_r <= {dvd_r[DIV_W-2:0], ge};
      rem_r <= ge ? rem_sub[SCALE_W-1:0] : rem_sh[SCALE_W-1:0];
    end
  end

  // Sign and saturation
  logic                pos_ovf, neg_ovf;
  logic [WEIGHT_W-1:0] w_sat, w_r;

  assign pos_ovf = |dvd_r[DIV_W-1:WEIGHT_W-1];
  assign neg_ovf = (|dvd_r[DIV_W-1:WEIGHT_W])
                || (dvd_r[WEIGHT_W-1] && (|dvd_r[WEIGHT_W-2:0]));

  always_comb begin
    if (zero_r) begin
      w_sat = '0;
    end else if (neg_r) begin
      w_sat = neg_ovf ? W_MIN : (~dvd_r[WEIGHT_W-1:0] + 1'b1);
    end else begin
      w_sat = pos_ovf ? W_MAX : dvd_r[WEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sat) begin
      w_r <= w_sat;
    end
  end

  // Logger state
  logic [1:0]          mode_r, mode_nxt;
  logic [TIME_W-1:0]   start_r, start_nxt;
  logic [WEIGHT_W-1:0] held_r, held_nxt;
  logic [1:0]          ev;

  // Threshold compares
  logic [WEIGHT_W:0]   wd, dabs;
  logic [TIME_W-1:0]   elapsed;
  logic [WEIGHT_W-1:0] pres_ext;
  logic gt_pres_r, lt_pres_r, d_gt_r, d2_lt_r, el_ge_r;

  assign wd       = {w_r[WEIGHT_W-1], w_r} - {held_r[WEIGHT_W-1], held_r};
  assign dabs     = wd[WEIGHT_W] ? (~wd + 1'b1) : wd;
  assign elapsed  = now_r - start_r;
  assign pres_ext = {{(WEIGHT_W-THR_W){1'b0}}, pres_r};

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      gt_pres_r <= $signed(w_r) > $signed(pres_ext);
      lt_pres_r <= $signed(w_r) < $signed(pres_ext);
      d_gt_r    <= dabs > {{(WEIGHT_W+1-THR_W){1'b0}}, chg_r};
      d2_lt_r   <= {dabs, 1'b0} < {{(WEIGHT_W+2-THR_W){1'b0}}, chg_r};
      el_ge_r   <= elapsed >= {{(TIME_W-THR_W){1'b0}}, settle_r};
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    start_nxt = start_r;
    held_nxt  = held_r;
    ev        = EV_NONE;
    case (mode_r)
      MODE_IDLE: begin
        if (gt_pres_r) begin
          mode_nxt  = MODE_WEIGHING;
          start_nxt = now_r;
        end
      end
      MODE_WEIGHING: begin
        if (lt_pres_r) begin
          mode_nxt = MODE_IDLE;
        end else if (el_ge_r) begin
          held_nxt = w_r;
          mode_nxt = MODE_LOGGED;
          ev       = EV_LOGGED;
        end
      end
      MODE_LOGGED: begin
        if (lt_pres_r) begin
          mode_nxt = MODE_IDLE;
          ev       = EV_REMOVED;
        end else if (d_gt_r) begin
          mode_nxt  = MODE_REWEIGHING;
          start_nxt = now_r;
        end
      end
      default: begin
        if (d2_lt_r) begin
          mode_nxt = MODE_LOGGED;
        end else if (el_ge_r) begin
          held_nxt = w_r;
          mode_nxt = MODE_LOGGED;
          ev       = EV_UPDATED;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      start_r <= '0;
      held_r  <= '0;
    end else if (cmd.commit) begin
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
      held_r  <= held_nxt;
    end
  end

  // Result register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.mode        <= mode_nxt;
      out_data.weight      <= w_r;
      out_data.event_res   <= ev;
      out_data.held_weight <= held_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.out_free = !out_valid_r || out_ready;

  `WSEL_ASSERT_NEXT(a_commit_shows, clk, rst_n, cmd.commit, out_valid)
  `WSEL_ASSERT_NOW(a_log_held, clk, rst_n, out_valid && (out_data.event_res == EV_LOGGED || out_data.event_res == EV_UPDATED), (out_data.mode == MODE_LOGGED) && (out_data.held_weight == out_data.weight))
  `WSEL_ASSERT_NOW(a_removed_idle, clk, rst_n, out_valid && (out_data.event_res == EV_REMOVED), out_data.mode == MODE_IDLE)

endmodule

FILE: tb/weight_settle_event_logger_top_test.sv
`timescale 1ns / 1ps

module weight_settle_event_logger_top_test;
  import wsel_pkg::*;

  // Weight fraction bits of the instance under test
  localparam int FRAC_BITS = WEIGHT_FRAC_BITS_DEF;

  // Limits of a raw reading and of a weight, in 64-bit terms
  localparam longint RAW_HI = (longint'(1) <<< (RAW_BITS - 1)) - 1;
  localparam longint RAW_LO = -(longint'(1) <<< (RAW_BITS - 1));
  localparam longint W_HI   = 64'sd2147483647;
  localparam longint W_LO   = -64'sd2147483648;

  localparam logic [SCALE_W-1:0] SCALE_MAX = '1;
  localparam logic [THR_W-1:0]   THR_MAX   = '1;

  // Indexes that map to no register; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  // When draining, wait well past the time that a valid reading takes
  localparam int DRAIN_CYCLES = 64;
  localparam int TAIL_CYCLES  = 100;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  wsel_in_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  wsel_out_t            out_data;

  weight_settle_event_logger_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register copies as the logger sees them
  logic signed [RAW_BITS-1:0] cur_tare;
  logic [SCALE_W-1:0]         cur_scale;
  logic [THR_W-1:0]           cur_pres;
  logic [THR_W-1:0]           cur_chg;
  logic [THR_W-1:0]           cur_settle;

  // Logger state: mode, start of the settle window, last logged weight
  logic [1:0]                 log_mode;
  logic [TIME_W-1:0]          log_start;
  longint                     log_held;

  // Results owed by the block, oldest first
  wsel_out_t                  pending_results[$];

  logic [TIME_W-1:0]          clock_ms;
  int unsigned                readings_sent;
  bit                         gaps_on = 1'b1;
  int                         hold_left = 0;
  int                         fail_count = 0;

  // ---------------------------------------------------------------------------
  // Weight and logger prediction
  // ---------------------------------------------------------------------------

  // Tare, scale to 2^-FRAC_BITS g, truncate toward zero and clamp to 32 bits.
  // A zero scale pins the weight to the limit on the side of the difference.
  function automatic longint scale_weight(input logic signed [RAW_BITS-1:0] raw);
    longint span;
    longint quo;
    span = longint'(raw) - longint'(cur_tare);
    if (cur_scale == '0) begin
      return (span > 0) ? W_HI : ((span < 0) ? W_LO : 0);
    end
    quo = (span * (longint'(1) <<< (8 + FRAC_BITS))) / longint'(cur_scale);
    if (quo > W_HI) quo = W_HI;
    if (quo < W_LO) quo = W_LO;
    return quo;
  endfunction

  // Advance the logger by one valid reading and queue the result it owes.
  task automatic step_logger(input wsel_in_t beat);
    wsel_out_t         want;
    longint            w;
    longint            gap;
    logic [TIME_W-1:0] elapsed;
    logic [1:0]        ev;
    w = scale_weight(beat.raw_reading);
    // elapsed time wraps with the millisecond counter
    elapsed = beat.time_ms - log_start;
    gap = (w > log_held) ? w - log_held : log_held - w;
    ev = EV_NONE;
    case (log_mode)
      MODE_IDLE: begin
        if (w > longint'(cur_pres)) begin
          log_mode = MODE_WEIGHING;
          log_start = beat.time_ms;
        end
      end
      MODE_WEIGHING: begin
        if (w < longint'(cur_pres)) begin
          log_mode = MODE_IDLE;
        end else if (elapsed >= cur_settle) begin
          log_held = w;
          log_mode = MODE_LOGGED;
          ev = EV_LOGGED;
        end
      end
      MODE_LOGGED: begin
        if (w < longint'(cur_pres)) begin
          log_mode = MODE_IDLE;
          ev = EV_REMOVED;
        end else if (gap > longint'(cur_chg)) begin
          log_mode = MODE_REWEIGHING;
          log_start = beat.time_ms;
        end
      end
      default: begin
        // reweighing: no removal check here, only cancel or settle
        if (2 * gap < longint'(cur_chg)) begin
          log_mode = MODE_LOGGED;
        end else if (elapsed >= cur_settle) begin
          log_held = w;
          log_mode = MODE_LOGGED;
          ev = EV_UPDATED;
        end
      end
    endcase
    want.mode        = log_mode;
    want.weight      = w[WEIGHT_W-1:0];
    want.event_res   = ev;
    want.held_weight = log_held[WEIGHT_W-1:0];
    pending_results.push_back(want);
  endtask

  // ---------------------------------------------------------------------------
  // Drive helpers
  // ---------------------------------------------------------------------------

  function automatic wsel_in_t make_beat(input logic ok, input logic [RAW_BITS-1:0] raw,
                                         input logic [TIME_W-1:0] t);
    wsel_in_t beat;
    beat.read_ok     = ok;
    beat.raw_reading = raw;
    beat.time_ms     = t;
    return beat;
  endfunction

  // Raw reading that lands near weight w under the current tare and scale.
  function automatic logic [RAW_BITS-1:0] raw_for_weight(input longint w);
    longint r;
    if (cur_scale == '0) begin
      r = longint'(cur_tare) + ((w > 0) ? 1 : ((w < 0) ? -1 : 0));
    end else begin
      r = longint'(cur_tare) + (w * longint'(cur_scale)) / (longint'(1) <<< (8 + FRAC_BITS));
    end
    if (r > RAW_HI) r = RAW_HI;
    if (r < RAW_LO) r = RAW_LO;
    return r[RAW_BITS-1:0];
  endfunction

  // Random offset in [-j, j].
  function automatic longint wobble(input longint j);
    return longint'($urandom_range(0, 2 * j)) - j;
  endfunction

  // Offer one beat and hold it until the block takes it. Valid is left high
  // after the handshake; the next call either replaces the payload or drops
  // valid first, both at the following falling edge.
  task automatic send_reading(input wsel_in_t beat);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 8) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = beat;
    do @(posedge clk); while (!in_ready);
    if (beat.read_ok) step_logger(beat);
  endtask

  task automatic read_at(input longint w, input logic [TIME_W-1:0] t);
    clock_ms = t;
    send_reading(make_beat(1'b1, raw_for_weight(w), t));
    readings_sent++;
  endtask

  // Advance the clock by dt and send a valid reading; now and then slip a
  // dead reading in first, which the block must swallow without a result.
  task automatic offer(input longint w, input int unsigned dt);
    if ($urandom_range(99) < 4) send_reading(make_beat(1'b0, RAW_BITS'($urandom), $urandom));
    read_at(w, clock_ms + dt);
  endtask

  // Drop valid, wait for every owed result, then let the block go quiet.
  task automatic quiesce();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_TARE:   cur_tare   = data[RAW_BITS-1:0];
      REG_SCALE:  cur_scale  = data[SCALE_W-1:0];
      REG_PRES:   cur_pres   = data[THR_W-1:0];
      REG_CHG:    cur_chg    = data[THR_W-1:0];
      REG_SETTLE: cur_settle = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  // Rewrite every register; junk in the unused upper bits of the 16-bit ones.
  task automatic apply_config(input logic [RAW_BITS-1:0] tare,
                              input logic [SCALE_W-1:0] scale,
                              input logic [THR_W-1:0] pres, chg, settle);
    quiesce();
    write_reg(REG_TARE, tare);
    write_reg(REG_SCALE, scale);
    write_reg(REG_PRES, {8'($urandom), pres});
    write_reg(REG_CHG, {8'($urandom), chg});
    write_reg(REG_SETTLE, {8'($urandom), settle});
  endtask

  // One object on the scale: place it, let it settle and log, maybe change
  // it (settle again or fall back), then usually take it off.
  task automatic run_session();
    longint      w_obj;
    longint      w_new;
    longint      jit;
    longint      pres;
    int unsigned step_max;
    int          k;
    pres     = longint'(cur_pres);
    jit      = longint'(cur_chg) / 4;
    step_max = cur_settle / 2 + 2;
    w_obj    = pres + 1 + longint'($urandom_range(0, 4 * cur_chg + 2000));
    // brush past the presence line and back off
    if ($urandom_range(9) == 0) begin
      offer(w_obj, $urandom_range(0, step_max));
      offer(pres - 1 - longint'($urandom_range(0, cur_pres)), $urandom_range(0, step_max));
    end
    k = 0;
    while (log_mode != MODE_LOGGED && k < 16) begin
      offer(w_obj + wobble(jit), $urandom_range(0, step_max));
      k++;
    end
    repeat ($urandom_range(0, 3)) offer(log_held + wobble(jit), $urandom_range(0, step_max));
    if ($urandom_range(99) < 60) begin
      w_new = longint'(cur_chg) + 1 + longint'($urandom_range(0, 2 * cur_chg + 500));
      w_new = $urandom_range(1) ? log_held + w_new : log_held - w_new;
      offer(w_new, $urandom_range(0, step_max));
      // fall back near the logged weight to cancel the reweigh
      if ($urandom_range(99) < 30) offer(log_held + wobble(jit), $urandom_range(0, step_max));
      k = 0;
      while (log_mode == MODE_REWEIGHING && k < 16) begin
        offer(w_new + wobble(jit), $urandom_range(0, step_max));
        k++;
      end
    end
    if ($urandom_range(99) < 80) begin
      offer(pres - 1 - longint'($urandom_range(0, cur_pres)), $urandom_range(0, step_max));
    end
  endtask

  // Mostly well-formed sessions, with fully random beats mixed in.
  task automatic run_readings(input int unsigned budget);
    int unsigned goal;
    wsel_in_t    junk;
    goal = readings_sent + budget;
    while (readings_sent < goal) begin
      if ($urandom_range(99) < 12) begin
        junk = make_beat(1'($urandom_range(1)), RAW_BITS'($urandom), $urandom);
        send_reading(junk);
        if (junk.read_ok) readings_sent++;
      end else begin
        run_session();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes under the reset configuration, plus a dead reading.
  task automatic test_field_extremes();
    send_reading(make_beat(1'b0, RAW_BITS'(RAW_HI), '1));
    send_reading(make_beat(1'b1, RAW_BITS'(RAW_HI), '0));
    send_reading(make_beat(1'b1, RAW_BITS'(RAW_LO), '1));
    send_reading(make_beat(1'b1, '0, 32'h5555_AAAA));
  endtask

  // Every transition of the logger, the settle boundary hit exactly, and a
  // settle window that straddles the wrap of the millisecond counter.
  task automatic test_state_walk();
    read_at(400, 32'd1000);    // idle -> weighing
    read_at(400, 32'd2000);    // still settling
    read_at(400, 32'd4000);    // settle time met exactly: logged
    read_at(800, 32'd4500);    // large change: reweighing
    read_at(450, 32'd5000);    // back within half the change: logged, no event
    read_at(1000, 32'd5500);   // reweighing again
    read_at(1000, 32'd8499);   // one ms short
    read_at(1000, 32'd8500);   // updated weight logged
    read_at(1000, 32'd9000);   // steady while logged
    read_at(100, 32'd9500);    // removed
    read_at(300, 32'd9600);    // weighing
    read_at(100, 32'd9700);    // dropped below presence while weighing
    read_at(400, 32'hFFFF_FC00);
    read_at(400, 32'h0000_0010);
    read_at(400, 32'h0000_0800);
    read_at(50, 32'h0000_0900);
  endtask

  // Zero scale, saturation both ways, the largest scale, and writes to
  // indexes that hold no register.
  task automatic test_scale_corners();
    quiesce();
    write_reg(REG_SCALE, '0);
    send_reading(make_beat(1'b1, 24'd5, clock_ms));
    send_reading(make_beat(1'b1, -24'sd5, clock_ms));
    send_reading(make_beat(1'b1, '0, clock_ms));
    quiesce();
    write_reg(REG_TARE, CFG_W'(RAW_HI));
    write_reg(REG_SCALE, 24'd1);
    send_reading(make_beat(1'b1, RAW_BITS'(RAW_LO), clock_ms));
    quiesce();
    write_reg(REG_TARE, CFG_W'(RAW_LO));
    send_reading(make_beat(1'b1, RAW_BITS'(RAW_HI), clock_ms));
    quiesce();
    write_reg(REG_SCALE, SCALE_MAX);
    send_reading(make_beat(1'b1, RAW_BITS'(RAW_HI), clock_ms + 32'd100));
    quiesce();
    for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++) begin
      write_reg(CFG_IDX_W'(i), CFG_W'($urandom));
    end
    send_reading(make_beat(1'b1, '0, clock_ms + 32'd200));
  endtask

  task automatic test_default_sessions();
    apply_config(TARE_RST, SCALE_RST, PRES_RST, CHG_RST, SETTLE_RST);
    run_readings(300);
  endtask

  // Hold the result side off long enough that the block backs up and
  // stalls its input while the sender keeps offering beats.
  task automatic test_result_backpressure();
    hold_left = 600;
    repeat (4) run_session();
  endtask

  // Random configuration with no idling on either side.
  task automatic test_busy_random();
    apply_config(24'($urandom_range(0, 1 << 22)) - 24'(1 << 21),
                 SCALE_W'($urandom_range(2000, 400000)),
                 THR_W'($urandom_range(0, 4000)), THR_W'($urandom_range(0, 4000)),
                 THR_W'($urandom));
    gaps_on = 1'b0;
    run_readings(300);
    gaps_on = 1'b1;
  endtask

  // Low extremes: most negative tare, unit scale, zero thresholds and no
  // settle time. Session weights mostly come out as zero; the random beats mostly saturate.
  task automatic test_low_extremes();
    apply_config(RAW_BITS'(RAW_LO), 24'd1, '0, '0, '0);
    run_readings(80);
  endtask

  // High extremes: largest thresholds and settle time on a coarse scale.
  task automatic test_high_extremes();
    apply_config('0, 24'd16, THR_MAX, THR_MAX, THR_MAX);
    run_readings(120);
  endtask

  // Start just under the top of the millisecond counter so settle windows wrap.
  task automatic test_timer_wrap();
    apply_config(24'($urandom_range(0, 20000)) - 24'd10000,
                 SCALE_W'($urandom_range(20000, 200000)),
                 THR_W'($urandom_range(50, 500)), THR_W'($urandom_range(50, 500)),
                 THR_W'($urandom_range(0, 5000)));
    clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
    run_readings(220);
  endtask

  // Pause the sender until every owed result is back, several times.
  task automatic test_sender_pause();
    repeat (3) begin
      run_session();
      quiesce();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern and checks
  // ---------------------------------------------------------------------------

  // Drop ready at random, or for a counted stretch when a test asks for it.
  initial begin : result_sink
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ready = !(gaps_on && $urandom_range(99) < 8);
      end
    end
  end

  task automatic report_field(input string field, input longint want, input longint got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    fail_count++;
  endtask

  // Compare each result beat with the oldest owed result.
  always @(posedge clk) begin : check_results
    wsel_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result beat with nothing owed, weight %0d", $time,
                 out_data.weight);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.mode != want.mode) begin
          report_field("mode", longint'(want.mode), longint'(out_data.mode));
        end
        if (out_data.weight != want.weight) begin
          report_field("weight", longint'(want.weight), longint'(out_data.weight));
        end
        if (out_data.event_res != want.event_res) begin
          report_field("event_res", longint'(want.event_res), longint'(out_data.event_res));
        end
        if (out_data.held_weight != want.held_weight) begin
          report_field("held_weight", longint'(want.held_weight),
                       longint'(out_data.held_weight));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_TARE;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    clock_ms  = '0;
    readings_sent = 0;
    cur_tare   = TARE_RST;
    cur_scale  = SCALE_RST;
    cur_pres   = PRES_RST;
    cur_chg    = CHG_RST;
    cur_settle = SETTLE_RST;
    log_mode   = MODE_IDLE;
    log_start  = '0;
    log_held   = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_field_extremes();
    test_state_walk();
    test_scale_corners();
    test_default_sessions();
    test_result_backpressure();
    test_busy_random();
    test_low_extremes();
    test_high_extremes();
    test_timer_wrap();
    test_sender_pause();

    // drain everything, then give the block time to emit anything stray
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, set far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
